FILE: hdl/tbsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbsc_pkg;

    localparam int REGION_SLOTS = 32;
    localparam int SLOT_W       = $clog2(REGION_SLOTS);
    localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
    localparam int TIME_BITS    = 32;
    localparam int THR_W        = 10;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    // search phases
    localparam logic [2:0] PH_REPEAT      = 3'd0;
    localparam logic [2:0] PH_S0          = 3'd1;
    localparam logic [2:0] PH_S1          = 3'd2;
    localparam logic [2:0] PH_S2          = 3'd3;
    localparam logic [2:0] PH_END_THREADS = 3'd4;
    localparam logic [2:0] PH_END         = 3'd5;

    // sequential-phase comparison
    localparam logic [1:0] SQ_PASS      = 2'd0;
    localparam logic [1:0] SQ_INITIAL   = 2'd1;
    localparam logic [1:0] SQ_END_TURBO = 2'd2;
    localparam logic [1:0] SQ_END_SEQ   = 2'd3;

    typedef enum logic [1:0] {
        CFG_MAX_THREADS     = 2'd0,
        CFG_START_THREADS   = 2'd1,
        CFG_METRIC_MODE     = 2'd2,
        CFG_WRITE_THRESHOLD = 2'd3
    } t_cfg_idx;

    localparam logic [8:0]  RST_MAX_THREADS   = 9'd8;
    localparam logic [8:0]  RST_START_THREADS = 9'd2;
    localparam logic        RST_METRIC_MODE   = 1'b0;
    localparam logic [31:0] RST_THRESHOLD     = 32'd776;

    typedef struct packed {
        logic [2:0]       search_phase;
        logic [THR_W-1:0] trial_threads;
        logic [THR_W-1:0] last_threads;
        logic [THR_W-1:0] step_size;
        logic [THR_W-1:0] best_threads;
        logic [63:0]      best_cost;
        logic [31:0]      best_time;
        logic             time_only;
        logic             best_boost;
        logic [31:0]      par_time_off;
        logic [31:0]      par_time_on;
        logic [1:0]       seq_phase;
        logic             seq_time_only;
        logic             seq_best_boost;
        logic [31:0]      seq_time_off;
        logic [31:0]      seq_time_on;
        logic [63:0]      seq_cost_off;
        logic [63:0]      seq_cost_on;
    } t_slot;

    typedef struct packed {
        logic load;
        logic rd_prev;
        logic wr_seq;
        logic scan_clr;
        logic rd_key;
        logic scan_inc;
        logic alloc;
        logic rd_slot;
        logic commit_begin;
        logic rd_cur;
        logic commit_end;
    } t_cmd;

    typedef struct packed {
        logic op_end;
        logic scan_end;
        logic key_hit;
        logic full;
        logic out_free;
    } t_sts;

    function automatic t_slot slot_setup(input logic [8:0] max_thr, input logic mode);
        t_slot s;
        s               = '0;
        s.search_phase  = PH_REPEAT;
        s.trial_threads = THR_W'(max_thr);
        s.time_only     = ~mode;
        s.seq_time_only = ~mode;
        s.seq_phase     = SQ_PASS;
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tbsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  tbsc_pkg::t_sts  i_sts,
    output tbsc_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SEQ_RD   = 10'b00_0000_0010,
        ST_SEQ_WR   = 10'b00_0000_0100,
        ST_SCAN_RD  = 10'b00_0000_1000,
        ST_SCAN_CMP = 10'b00_0001_0000,
        ST_ALLOC    = 10'b00_0010_0000,
        ST_REC_RD   = 10'b00_0100_0000,
        ST_BEG_FIN  = 10'b00_1000_0000,
        ST_END_RD   = 10'b01_0000_0000,
        ST_END_WR   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.op_end ? ST_END_RD : ST_SEQ_RD;
                end
            end
            ST_SEQ_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = ST_SEQ_WR;
            end
            ST_SEQ_WR: begin
                o_cmd.wr_seq   = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_state = ST_ALLOC;
                end else begin
                    o_cmd.rd_key = 1'b1;
                    n_state      = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_sts.key_hit) begin
                    n_state = ST_REC_RD;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_SCAN_RD;
                end
            end
            ST_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = i_sts.full ? ST_BEG_FIN : ST_REC_RD;
            end
            ST_REC_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = ST_BEG_FIN;
            end
            ST_BEG_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit_begin = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_END_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = ST_END_WR;
            end
            ST_END_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.commit_end = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/tbsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsc_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_op,
    input  wire  [63:0]          i_key,
    input  wire  [31:0]          i_time,
    input  wire  [31:0]          i_energy,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_addr,
    input  wire  [31:0]          i_cfg_wdata,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [8:0]           o_thread_count,
    output logic                 o_boost_write,
    output logic                 o_boost_value,
    output logic                 o_table_full,
    output logic [4:0]           o_region_slot,
    input  tbsc_pkg::t_cmd       i_cmd,
    output tbsc_pkg::t_sts       o_sts
);

    localparam int SW = tbsc_pkg::SLOT_W;
    localparam int CW = tbsc_pkg::CNT_W;
    localparam int TW = tbsc_pkg::THR_W;

    // configuration
    logic [8:0]  r_max_thr, r_start_thr;
    logic        r_metric;
    logic [31:0] r_thresh;

    // item and globals
    logic [63:0] r_key;
    logic [31:0] r_t, r_e;
    logic [63:0] r_prod;
    logic [CW-1:0] r_used, r_idx;
    logic [SW-1:0] r_prev_slot, r_cur_slot;
    logic        r_boost_now, r_cur_tracked, r_seq_tracked, r_full;

    // stores
    tbsc_pkg::t_slot r_slot_mem [tbsc_pkg::REGION_SLOTS];
    logic [63:0]     r_key_mem  [tbsc_pkg::REGION_SLOTS];
    logic [tbsc_pkg::REGION_SLOTS-1:0] r_slot_vld;
    tbsc_pkg::t_slot r_rec_q;
    logic            r_rec_vld_q;
    logic [63:0]     r_key_q;

    logic        r_out_valid;
    logic [8:0]  r_thr_out;
    logic        r_bw_out, r_bv_out, r_full_out;
    logic [4:0]  r_slot_out;

    tbsc_pkg::t_slot rec, seq_rec, end_rec, wr_data;
    logic [SW-1:0] rd_addr, wr_addr;
    logic          rd_en, wr_en;
    logic          end_wr, end_bnew;
    logic          beg_wr;
    logic [TW-1:0] beg_thr;
    logic          out_free;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, tbsc_pkg::THR_MAX}) ? tbsc_pkg::THR_MAX : s[TW-1:0];
    endfunction

    function automatic logic worth(input logic bnow, input logic want, input logic [31:0] t_on,
                                   input logic [31:0] t_off, input logic [31:0] thr);
        logic [32:0] a, b;
        a = {1'b0, t_on} + {1'b0, thr};
        b = {1'b0, t_off} + {1'b0, thr};
        return (!bnow && want && (a < {1'b0, t_off})) || (bnow && !want && (b < {1'b0, t_on}));
    endfunction

    function automatic tbsc_pkg::t_slot finish(input tbsc_pkg::t_slot s, input logic [31:0] t);
        tbsc_pkg::t_slot r;
        r              = s;
        r.best_boost   = 1'b1;
        r.par_time_off = t;
        r.search_phase = tbsc_pkg::PH_END_THREADS;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_thr   <= tbsc_pkg::RST_MAX_THREADS;
            r_start_thr <= tbsc_pkg::RST_START_THREADS;
            r_metric    <= tbsc_pkg::RST_METRIC_MODE;
            r_thresh    <= tbsc_pkg::RST_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (tbsc_pkg::t_cfg_idx'(i_cfg_addr))
                tbsc_pkg::CFG_MAX_THREADS:     r_max_thr   <= i_cfg_wdata[8:0];
                tbsc_pkg::CFG_START_THREADS:   r_start_thr <= i_cfg_wdata[8:0];
                tbsc_pkg::CFG_METRIC_MODE:     r_metric    <= i_cfg_wdata[0];
                tbsc_pkg::CFG_WRITE_THRESHOLD: r_thresh    <= i_cfg_wdata;
            endcase
        end
    end

    // item capture and cost product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_t   <= 32'(i_time[tbsc_pkg::TIME_BITS-1:0]);
            r_e   <= i_energy;
        end
        r_prod <= 64'(r_t) * 64'(r_e);
    end

    assign rd_en   = i_cmd.rd_prev | i_cmd.rd_slot | i_cmd.rd_cur;
    assign rd_addr = i_cmd.rd_prev ? r_prev_slot :
                     i_cmd.rd_cur  ? r_cur_slot  : r_idx[SW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[SW-1:0];
        wr_data = tbsc_pkg::slot_setup(r_max_thr, r_metric);
        if (i_cmd.wr_seq && r_seq_tracked) begin
            wr_en   = 1'b1;
            wr_addr = r_prev_slot;
            wr_data = seq_rec;
        end else if (i_cmd.alloc && !o_sts.full) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit_end && r_cur_tracked) begin
            wr_en   = 1'b1;
            wr_addr = r_cur_slot;
            wr_data = end_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rec_q <= r_slot_mem[rd_addr];
        end
        if (i_cmd.alloc && !o_sts.full) begin
            r_key_mem[r_idx[SW-1:0]] <= r_key;
        end
        if (i_cmd.rd_key) begin
            r_key_q <= r_key_mem[r_idx[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld  <= '0;
            r_rec_vld_q <= 1'b0;
        end else begin
            if (wr_en) begin
                r_slot_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rec_vld_q <= r_slot_vld[rd_addr];
            end
        end
    end

    // a slot never written holds its reset set-up
    assign rec = r_rec_vld_q ? r_rec_q
                             : tbsc_pkg::slot_setup(tbsc_pkg::RST_MAX_THREADS,
                                                    tbsc_pkg::RST_METRIC_MODE);

    // score the sequential phase left by the previous region
    always_comb begin
        logic [63:0] cost;
        seq_rec = rec;
        cost    = rec.seq_time_only ? 64'(r_t) : r_prod;
        if (rec.seq_phase == tbsc_pkg::SQ_INITIAL || rec.seq_phase == tbsc_pkg::SQ_END_TURBO) begin
            if (!rec.seq_time_only && r_prod == '0) begin
                seq_rec.seq_phase      = tbsc_pkg::SQ_PASS;
                seq_rec.seq_time_only  = 1'b1;
                seq_rec.seq_best_boost = 1'b1;
            end else if (rec.seq_phase == tbsc_pkg::SQ_INITIAL) begin
                seq_rec.seq_time_off   = r_t;
                seq_rec.seq_cost_off   = cost;
                seq_rec.seq_best_boost = 1'b1;
                seq_rec.seq_phase      = tbsc_pkg::SQ_END_TURBO;
            end else begin
                seq_rec.seq_time_on = r_t;
                seq_rec.seq_cost_on = cost;
                seq_rec.seq_phase   = tbsc_pkg::SQ_END_SEQ;
                if (rec.seq_cost_off < cost) begin
                    seq_rec.seq_best_boost = 1'b0;
                end
            end
        end
    end

    // parallel-phase search step and boost decision for the following sequential phase
    always_comb begin
        tbsc_pkg::t_slot s;
        logic [63:0]   cost;
        logic [TW-1:0] step;
        s    = rec;
        cost = rec.time_only ? 64'(r_t) : r_prod;
        step = rec.last_threads >> 1;
        if (s.search_phase != tbsc_pkg::PH_END) begin
            if (!s.time_only && r_prod == '0) begin
                s.search_phase = tbsc_pkg::PH_REPEAT;
                s.time_only    = 1'b1;
            end
            case (s.search_phase)
                tbsc_pkg::PH_REPEAT: begin
                    s.search_phase  = tbsc_pkg::PH_S0;
                    s.trial_threads = TW'(r_start_thr);
                    s.last_threads  = TW'(r_start_thr);
                end
                tbsc_pkg::PH_S0: begin
                    s.best_cost     = cost;
                    s.best_time     = r_t;
                    s.best_threads  = s.trial_threads;
                    s.trial_threads = sat_add(s.trial_threads, s.trial_threads);
                    s.search_phase  = tbsc_pkg::PH_S1;
                end
                tbsc_pkg::PH_S1: begin
                    if (cost < s.best_cost) begin
                        s.best_cost    = cost;
                        s.best_time    = r_t;
                        s.best_threads = s.trial_threads;
                        if ({s.trial_threads, 1'b0} <= (TW+1)'(r_max_thr)) begin
                            s.last_threads  = s.trial_threads;
                            s.trial_threads = sat_add(s.trial_threads, s.trial_threads);
                        end else begin
                            s.step_size = step;
                            if (step > TW'(1)) begin
                                s.trial_threads = (s.trial_threads > step)
                                                ? s.trial_threads - step : '0;
                                s.search_phase  = tbsc_pkg::PH_S2;
                            end else begin
                                s = finish(s, r_t);
                            end
                        end
                    end else if (s.best_threads == TW'(r_max_thr >> 1)) begin
                        s = finish(s, r_t);
                    end else begin
                        s.step_size = step;
                        if (step > TW'(1)) begin
                            s.trial_threads = sat_add(s.trial_threads, step);
                            s.search_phase  = tbsc_pkg::PH_S2;
                        end else begin
                            s = finish(s, r_t);
                        end
                    end
                end
                tbsc_pkg::PH_S2: begin
                    if (!(s.best_cost < cost)) begin
                        s.best_threads = s.trial_threads;
                        s.best_time    = r_t;
                        s.best_cost    = cost;
                    end
                    s.step_size = s.step_size >> 1;
                    if (s.step_size > TW'(1)) begin
                        s.trial_threads = sat_add(s.trial_threads, s.step_size);
                    end else begin
                        s = finish(s, r_t);
                    end
                end
                tbsc_pkg::PH_END_THREADS: begin
                    s.search_phase = tbsc_pkg::PH_END;
                    s.par_time_on  = r_t;
                    if (s.best_cost < cost) begin
                        s.best_boost = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        end_wr = 1'b0;
        case (s.seq_phase)
            tbsc_pkg::SQ_PASS: s.seq_phase = tbsc_pkg::SQ_INITIAL;
            tbsc_pkg::SQ_END_TURBO:
                end_wr = (s.best_boost != s.seq_best_boost) && (r_thresh < s.seq_time_off);
            tbsc_pkg::SQ_END_SEQ:
                end_wr = worth(r_boost_now, s.seq_best_boost, s.seq_time_on, s.seq_time_off,
                               r_thresh);
            default: ;
        endcase
        end_bnew = s.seq_best_boost;
        end_rec  = s;
    end

    // begin answer from the looked-up or new slot
    always_comb begin
        if (rec.search_phase == tbsc_pkg::PH_END) begin
            beg_wr  = worth(r_boost_now, rec.best_boost, rec.par_time_on, rec.par_time_off,
                            r_thresh);
            beg_thr = rec.best_threads;
        end else begin
            beg_wr  = (r_boost_now != rec.best_boost) && (rec.best_time > r_thresh);
            beg_thr = (rec.search_phase == tbsc_pkg::PH_END_THREADS) ? rec.best_threads
                                                                       : rec.trial_threads;
        end
        if (r_full) begin
            beg_wr  = 1'b0;
            beg_thr = TW'(r_max_thr);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_idx         <= '0;
            r_prev_slot   <= '0;
            r_cur_slot    <= SW'(tbsc_pkg::REGION_SLOTS - 1);
            r_boost_now   <= 1'b0;
            r_cur_tracked <= 1'b1;
            r_seq_tracked <= 1'b1;
            r_full        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_full <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.alloc) begin
                if (o_sts.full) begin
                    r_full <= 1'b1;
                end else begin
                    r_used <= r_used + CW'(1);
                end
            end
            if (i_cmd.commit_begin || i_cmd.commit_end) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit_begin) begin
                r_cur_tracked <= !r_full;
                r_cur_slot    <= r_full ? '0 : r_idx[SW-1:0];
                if (beg_wr) begin
                    r_boost_now <= rec.best_boost;
                end
            end
            if (i_cmd.commit_end) begin
                r_seq_tracked <= r_cur_tracked;
                if (r_cur_tracked) begin
                    r_prev_slot <= r_cur_slot;
                    if (end_wr) begin
                        r_boost_now <= end_bnew;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_begin) begin
            r_thr_out  <= (beg_thr > TW'(511)) ? 9'd511 : beg_thr[8:0];
            r_bw_out   <= beg_wr;
            r_bv_out   <= beg_wr ? rec.best_boost : r_boost_now;
            r_full_out <= r_full;
            r_slot_out <= r_full ? 5'd0 : 5'(r_idx[SW-1:0]);
        end else if (i_cmd.commit_end) begin
            r_thr_out  <= '0;
            r_bw_out   <= r_cur_tracked && end_wr;
            r_bv_out   <= (r_cur_tracked && end_wr) ? end_bnew : r_boost_now;
            r_full_out <= 1'b0;
            r_slot_out <= 5'(r_cur_slot);
        end
    end

    assign o_sts.op_end   = i_op;
    assign o_sts.scan_end = (r_idx == r_used);
    assign o_sts.key_hit  = (r_key_q == r_key);
    assign o_sts.full     = (r_used == CW'(tbsc_pkg::REGION_SLOTS));
    assign o_sts.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_thread_count = r_thr_out;
    assign o_boost_write  = r_bw_out;
    assign o_boost_value  = r_bv_out;
    assign o_table_full   = r_full_out;
    assign o_region_slot  = r_slot_out;

endmodule
`default_nettype wire

FILE: hdl/thread_boost_search_controller.sv
// A begin word scores the previous region's sequential phase, scans the stored keys one
// slot at a time (read, then compare), reads the matching or new slot (no read on a full
// table) and loads the result; an end word reads its slot and loads the result. One word
// is in flight at a time; the next is taken in the cycle after the result is loaded.
// Reset (synchronous, active low) clears the slot valid bits at once: every slot reads as
// freshly set up, regions_used 0, boost off, configuration at its reset values.
`timescale 1ns / 1ps
`default_nettype none
module thread_boost_search_controller (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [127:0] i_s_tdata,  // region_key[63:0], elapsed_time[95:64], energy_used[127:96]
    input  wire          i_s_tuser,  // operation
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // thread_count[8:0], boost_write[9], boost_value[10], table_full[11], region_slot[16:12]
    output logic [23:0]  o_m_tdata,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_addr,
    input  wire  [31:0]  i_cfg_wdata
);

    tbsc_pkg::t_cmd cmd;
    tbsc_pkg::t_sts sts;
    logic [8:0] thr;
    logic       bw, bv, full;
    logic [4:0] slot;

    tbsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tbsc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_s_tuser),
        .i_key          (i_s_tdata[63:0]),
        .i_time         (i_s_tdata[95:64]),
        .i_energy       (i_s_tdata[127:96]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_thread_count (thr),
        .o_boost_write  (bw),
        .o_boost_value  (bv),
        .o_table_full   (full),
        .o_region_slot  (slot),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

    assign o_m_tdata = {7'd0, slot, full, bv, bw, thr};

endmodule
`default_nettype wire

FILE: hdl/tbsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tbsc_props (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_s_tvalid,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [23:0]  o_m_tdata
);

    // one word at a time: no new word right after one is taken
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a word is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[11]) |-> (!o_m_tdata[9] && o_m_tdata[16:12] == 5'd0))
        else $error("full table answer with boost write or slot");

    // no result right after the input word is taken, unless one was already pending
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result before work done");

endmodule

bind thread_boost_search_controller tbsc_props u_tbsc_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

FILE: verif/tbsc_checker.sv
`timescale 1ns / 1ps
module tbsc_checker
    import tbsc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [127:0] i_s_tdata,
    input  wire          i_s_tuser,
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [23:0]  i_m_tdata,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_addr,
    input  wire  [31:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        logic [8:0] threads;
        logic       boost_wr;
        logic       boost_val;
        logic       full;
        logic [4:0] slot;
    } t_answer;

    t_answer answer_q[$];

    // configuration copy
    logic [8:0]  max_thr, start_thr;
    logic        mode;
    logic [31:0] thresh;

    // per-slot search state
    logic [63:0]      key_q     [REGION_SLOTS];
    logic [2:0]       phase     [REGION_SLOTS];
    logic [THR_W-1:0] trial     [REGION_SLOTS];
    logic [THR_W-1:0] last_thr  [REGION_SLOTS];
    logic [THR_W-1:0] step      [REGION_SLOTS];
    logic [THR_W-1:0] best_thr  [REGION_SLOTS];
    logic [63:0]      best_cost [REGION_SLOTS];
    logic [31:0]      best_t    [REGION_SLOTS];
    logic             t_only    [REGION_SLOTS];
    logic             b_boost   [REGION_SLOTS];
    logic [31:0]      par_off   [REGION_SLOTS];
    logic [31:0]      par_on    [REGION_SLOTS];
    logic [1:0]       sq        [REGION_SLOTS];
    logic             sq_t_only [REGION_SLOTS];
    logic             sq_boost  [REGION_SLOTS];
    logic [31:0]      sq_t_off  [REGION_SLOTS];
    logic [31:0]      sq_t_on   [REGION_SLOTS];
    logic [63:0]      sq_c_off  [REGION_SLOTS];
    logic [63:0]      sq_c_on   [REGION_SLOTS];

    int   used, prev_slot, cur_slot;
    logic boost_now, cur_trk, seq_trk;

    function automatic logic [THR_W-1:0] thr_add(input logic [THR_W-1:0] a, b);
        int s;
        s = int'(a) + int'(b);
        return (s > int'(THR_MAX)) ? THR_MAX : THR_W'(s);
    endfunction

    function automatic logic gain_worth(input logic want, input logic [31:0] t_on, t_off);
        logic [63:0] on64, off64, th64;
        on64  = 64'(t_on);
        off64 = 64'(t_off);
        th64  = 64'(thresh);
        if (!boost_now && want && on64 + th64 < off64) return 1'b1;
        if (boost_now && !want && off64 + th64 < on64) return 1'b1;
        return 1'b0;
    endfunction

    task automatic slot_init(input int i);
        key_q[i]     = '0;
        phase[i]     = PH_REPEAT;
        trial[i]     = THR_W'(max_thr);
        last_thr[i]  = '0;
        step[i]      = '0;
        best_thr[i]  = '0;
        best_cost[i] = '0;
        best_t[i]    = '0;
        t_only[i]    = ~mode;
        b_boost[i]   = 1'b0;
        par_off[i]   = '0;
        par_on[i]    = '0;
        sq[i]        = SQ_PASS;
        sq_t_only[i] = ~mode;
        sq_boost[i]  = 1'b0;
        sq_t_off[i]  = '0;
        sq_t_on[i]   = '0;
        sq_c_off[i]  = '0;
        sq_c_on[i]   = '0;
    endtask

    task automatic model_reset();
        max_thr   = RST_MAX_THREADS;
        start_thr = RST_START_THREADS;
        mode      = RST_METRIC_MODE;
        thresh    = RST_THRESHOLD;
        for (int i = 0; i < REGION_SLOTS; i++) slot_init(i);
        used      = 0;
        prev_slot = 0;
        cur_slot  = REGION_SLOTS - 1;
        boost_now = 1'b0;
        cur_trk   = 1'b1;
        seq_trk   = 1'b1;
        answer_q.delete();
    endtask

    // sequential phase following the previous region, boost off then on
    task automatic score_seq(input logic [31:0] t, input logic [31:0] e);
        int p;
        logic [63:0] cost;
        p = prev_slot;
        if (!seq_trk) return;
        if (sq[p] != SQ_INITIAL && sq[p] != SQ_END_TURBO) return;
        cost = 64'(t);
        if (!sq_t_only[p]) begin
            cost = 64'(t) * 64'(e);
            if (cost == 0) begin
                sq[p]        = SQ_PASS;
                sq_t_only[p] = 1'b1;
                sq_boost[p]  = 1'b1;
            end
        end
        if (sq[p] == SQ_INITIAL) begin
            sq_t_off[p] = t;
            sq_c_off[p] = cost;
            sq_boost[p] = 1'b1;
            sq[p]       = SQ_END_TURBO;
        end else if (sq[p] == SQ_END_TURBO) begin
            sq_t_on[p] = t;
            sq_c_on[p] = cost;
            sq[p]      = SQ_END_SEQ;
            if (sq_c_off[p] < sq_c_on[p]) sq_boost[p] = 1'b0;
        end
    endtask

    task automatic threads_done(input int s, input logic [31:0] t);
        b_boost[s] = 1'b1;
        par_off[s] = t;
        phase[s]   = PH_END_THREADS;
    endtask

    task automatic advance_search(input int s, input logic [31:0] t, input logic [31:0] e);
        logic [63:0] cost;
        if (phase[s] == PH_END) return;
        cost = 64'(t);
        if (!t_only[s]) begin
            cost = 64'(t) * 64'(e);
            if (cost == 0) begin
                phase[s]  = PH_REPEAT;
                t_only[s] = 1'b1;
            end
        end
        case (phase[s])
            PH_REPEAT: begin
                phase[s]    = PH_S0;
                trial[s]    = THR_W'(start_thr);
                last_thr[s] = THR_W'(start_thr);
            end
            PH_S0: begin
                best_cost[s] = cost;
                best_t[s]    = t;
                best_thr[s]  = trial[s];
                trial[s]     = thr_add(trial[s], trial[s]);
                phase[s]     = PH_S1;
            end
            PH_S1: begin
                if (cost < best_cost[s]) begin
                    best_cost[s] = cost;
                    best_t[s]    = t;
                    best_thr[s]  = trial[s];
                    if (int'(trial[s]) * 2 <= int'(max_thr)) begin
                        last_thr[s] = trial[s];
                        trial[s]    = thr_add(trial[s], trial[s]);
                    end else begin
                        step[s] = last_thr[s] / 2;
                        if (step[s] >= 2) begin
                            trial[s] = (trial[s] > step[s]) ? trial[s] - step[s] : '0;
                            phase[s] = PH_S2;
                        end else begin
                            threads_done(s, t);
                        end
                    end
                end else if (best_thr[s] == THR_W'(max_thr / 2)) begin
                    threads_done(s, t);
                end else begin
                    step[s] = last_thr[s] / 2;
                    if (step[s] >= 2) begin
                        trial[s] = thr_add(trial[s], step[s]);
                        phase[s] = PH_S2;
                    end else begin
                        threads_done(s, t);
                    end
                end
            end
            PH_S2: begin
                if (!(best_cost[s] < cost)) begin
                    best_thr[s]  = trial[s];
                    best_t[s]    = t;
                    best_cost[s] = cost;
                end
                step[s] = step[s] / 2;
                if (step[s] >= 2) trial[s] = thr_add(trial[s], step[s]);
                else threads_done(s, t);
            end
            PH_END_THREADS: begin
                phase[s]  = PH_END;
                par_on[s] = t;
                if (best_cost[s] < cost) b_boost[s] = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic predict_word(input logic is_end, input logic [63:0] key,
                                input logic [31:0] t, input logic [31:0] e,
                                output t_answer a);
        int i, s;
        logic found;
        logic [THR_W-1:0] thr;
        thr = '0;
        a.boost_wr = 1'b0;
        a.full = 1'b0;
        if (!is_end) begin
            found = 1'b0;
            score_seq(t, e);
            for (i = 0; i < used; i++) begin
                if (key_q[i] == key) begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found) begin
                if (used < REGION_SLOTS) begin
                    i = used;
                    slot_init(i);
                    key_q[i] = key;
                    used++;
                end else begin
                    a.full = 1'b1;
                end
            end
            if (a.full) begin
                cur_trk  = 1'b0;
                cur_slot = 0;
                thr      = THR_W'(max_thr);
            end else begin
                cur_trk  = 1'b1;
                cur_slot = i;
                s = i;
                if (phase[s] == PH_END) begin
                    if (gain_worth(b_boost[s], par_on[s], par_off[s])) begin
                        a.boost_wr = 1'b1;
                        boost_now  = b_boost[s];
                    end
                    thr = best_thr[s];
                end else begin
                    if (boost_now != b_boost[s] && best_t[s] > thresh) begin
                        a.boost_wr = 1'b1;
                        boost_now  = b_boost[s];
                    end
                    thr = (phase[s] == PH_END_THREADS) ? best_thr[s] : trial[s];
                end
            end
        end else if (cur_trk) begin
            s = cur_slot;
            advance_search(s, t, e);
            if (sq[s] == SQ_PASS) begin
                sq[s] = SQ_INITIAL;
            end else if (sq[s] == SQ_END_TURBO) begin
                if (b_boost[s] != sq_boost[s] && thresh < sq_t_off[s]) begin
                    a.boost_wr = 1'b1;
                    boost_now  = sq_boost[s];
                end
            end else if (sq[s] == SQ_END_SEQ) begin
                if (gain_worth(sq_boost[s], sq_t_on[s], sq_t_off[s])) begin
                    a.boost_wr = 1'b1;
                    boost_now  = sq_boost[s];
                end
            end
            prev_slot = cur_slot;
            seq_trk   = 1'b1;
        end else begin
            seq_trk = 1'b0;
        end
        a.threads   = (thr > 511) ? 9'd511 : thr[8:0];
        a.boost_val = boost_now;
        a.slot      = cur_slot[4:0];
    endtask

    always @(posedge i_clk) begin
        t_answer exp_a, got;
        if (!i_rst_n) begin
            model_reset();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_MAX_THREADS:     max_thr   = i_cfg_wdata[8:0];
                    CFG_START_THREADS:   start_thr = i_cfg_wdata[8:0];
                    CFG_METRIC_MODE:     mode      = i_cfg_wdata[0];
                    CFG_WRITE_THRESHOLD: thresh    = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.threads   = i_m_tdata[8:0];
                got.boost_wr  = i_m_tdata[9];
                got.boost_val = i_m_tdata[10];
                got.full      = i_m_tdata[11];
                got.slot      = i_m_tdata[16:12];
                if (answer_q.size() == 0) begin
                    $error("result word with nothing expected: %h", i_m_tdata);
                    o_errors++;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (got.threads !== exp_a.threads) begin
                        $error("thread_count exp %0d got %0d", exp_a.threads, got.threads);
                        o_errors++;
                    end
                    if (got.boost_wr !== exp_a.boost_wr) begin
                        $error("boost_write exp %0b got %0b", exp_a.boost_wr, got.boost_wr);
                        o_errors++;
                    end
                    if (got.boost_val !== exp_a.boost_val) begin
                        $error("boost_value exp %0b got %0b", exp_a.boost_val, got.boost_val);
                        o_errors++;
                    end
                    if (got.full !== exp_a.full) begin
                        $error("table_full exp %0b got %0b", exp_a.full, got.full);
                        o_errors++;
                    end
                    if (got.slot !== exp_a.slot) begin
                        $error("region_slot exp %0d got %0d", exp_a.slot, got.slot);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_word(i_s_tuser, i_s_tdata[63:0], i_s_tdata[95:64],
                             i_s_tdata[127:96], exp_a);
                answer_q.push_back(exp_a);
            end
        end
        o_pending = answer_q.size();
    end

endmodule

FILE: verif/tb_thread_boost_search_controller.sv
`timescale 1ns / 1ps
module tb_thread_boost_search_controller;
    import tbsc_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [23:0]  o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    int   errors, pending;
    logic calm = 1'b0;   // no idling on either side while set
    logic [63:0] key_pool [40];

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_END   = 1'b1;

    always #1 i_clk = ~i_clk;

    thread_boost_search_controller dut (.*);

    tbsc_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending)
    );

    task automatic send_word(input logic op, input logic [63:0] key,
                             input logic [31:0] t, input logic [31:0] e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {e, t, key};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic cfg_all(input logic [8:0] mx, input logic [8:0] st, input logic md,
                           input logic [31:0] th);
        drain();
        cfg_write(CFG_MAX_THREADS, 32'(mx));
        cfg_write(CFG_START_THREADS, 32'(st));
        cfg_write(CFG_METRIC_MODE, 32'(md));
        cfg_write(CFG_WRITE_THRESHOLD, th);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1, 2: return $urandom;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // result side: random stall before each word
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = calm ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                i_m_tready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int lim, k;
        for (int i = 0; i < 40; i++) key_pool[i] = {$urandom, $urandom};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: end with no region yet, key extremes, time/energy extremes
        send_word(OP_END, 64'd0, 32'd100, 32'd5);
        send_word(OP_BEGIN, 64'd0, 32'd0, 32'd0);
        send_word(OP_END, 64'd0, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_BEGIN, '1, 32'd50, 32'd0);
        send_word(OP_END, '1, 32'd1, 32'd1);
        send_word(OP_BEGIN, 64'd0, 32'd2000, 32'd1);
        send_word(OP_END, 64'd0, 32'd10, 32'd1);
        send_word(OP_BEGIN, 64'd0, 32'd10, 32'd1);
        send_word(OP_END, 64'd0, 32'd5, 32'd1);
        send_word(OP_END, 64'd0, 32'd5, 32'd1);
        cfg_all(9'd256, 9'd3, 1'b1, 32'd0);
        send_word(OP_BEGIN, key_pool[0], 32'd100, 32'd0);
        send_word(OP_END, key_pool[0], 32'd100, 32'd0);
        send_word(OP_BEGIN, key_pool[0], 32'd0, 32'd7);
        send_word(OP_END, key_pool[0], 32'd300, 32'd3);
        send_word(OP_BEGIN, key_pool[1], 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_END, key_pool[1], 32'd300, 32'd3);
        cfg_all(9'd1, 9'd256, 1'b0, 32'hffff_ffff);
        send_word(OP_BEGIN, key_pool[2], 32'd1, 32'd1);
        send_word(OP_END, key_pool[2], 32'd1, 32'd1);

        // random: phases of settings, region pool widening so allocation spreads out
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: cfg_all(9'd8, 9'd2, 1'b0, 32'd776);
                1: cfg_all(9'd256, 9'd5, 1'b1, 32'd0);
                2: cfg_all(9'd16, 9'd1, 1'b1, 32'd1000);
                3: cfg_all(9'd1, 9'd256, 1'b0, 32'hffff_ffff);
                default: cfg_all(9'd64, 9'd3, 1'b0, 32'd200);
            endcase
            calm = (ph == 2);
            lim = (ph * 8 + 8 > 40) ? 40 : ph * 8 + 8;
            k = 0;
            while (k < 360) begin
                if (ph == 1 && k == 180) drain();
                if ($urandom_range(0, 99) < 85) begin
                    int idx;
                    idx = $urandom_range(0, lim - 1);
                    send_word(OP_BEGIN, key_pool[idx], rand_time(), rand_energy());
                    send_word(OP_END, key_pool[idx], rand_time(), rand_energy());
                    k += 2;
                end else begin
                    send_word(logic'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                  : key_pool[$urandom_range(0, lim - 1)],
                              rand_time(), rand_energy());
                    k++;
                end
            end
        end
        calm = 1'b0;
        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/tbsc_pkg.sv
hdl/tbsc_ctrl.sv
hdl/tbsc_datapath.sv
hdl/thread_boost_search_controller.sv
hdl/tbsc_checker.sv
verif/tbsc_checker.sv
verif/tb_thread_boost_search_controller.sv
